// ===== hdl/ntwa_pkg.sv =====
// Package for the neighbor table with aging: table geometry, field widths,
// status and mode codes and the layout of one stored table entry.
// Used by neighbor_table_with_aging_unit; depends on nothing else.
package ntwa_pkg;

    // table geometry
    localparam int NUM_IFACES          = 4;
    localparam int NEIGHBORS_PER_IFACE = 8;
    localparam int TABLE_SIZE          = NUM_IFACES * NEIGHBORS_PER_IFACE;

    // derived widths
    localparam int ADDR_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int SLOT_W  = (NEIGHBORS_PER_IFACE > 1) ? $clog2(NEIGHBORS_PER_IFACE) : 1;
    localparam int OWNER_W = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int CNT_W   = $clog2(NEIGHBORS_PER_IFACE + 1);
    localparam int STEP_W  = $clog2(TABLE_SIZE + 1);
    localparam int SUM_W   = $clog2(TABLE_SIZE + 1);

    // fixed field widths
    localparam int IFACE_W   = 2;
    localparam int WORD_W    = 32;
    localparam int AGE_W     = 10;
    localparam int CTR_W     = 12;
    localparam int INTV_W    = 8;
    localparam int CFG_IDX_W = 8;

    // limits
    localparam logic [AGE_W-1:0] AGE_MAX     = 10'd1023;
    localparam logic [CTR_W-1:0] COUNTER_MAX = 12'd4095;
    localparam int IFACE_CNT_SAT = 15;
    localparam int WIDE_CNT_SAT  = 63;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HELLO_INTERVAL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 8'd1;
    localparam logic [INTV_W-1:0] HELLO_INTERVAL_RESET  = 8'd5;
    localparam logic [INTV_W-1:0] UPDATE_INTERVAL_RESET = 8'd30;

    // item kinds
    localparam logic MODE_HELLO = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_REFRESHED = 2'd0;
    localparam logic [1:0] STATUS_ADDED     = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_TICK_DONE = 2'd3;

    // one stored neighbor entry
    typedef struct packed {
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] ip;
        logic [WORD_W-1:0] mask;
        logic [AGE_W-1:0]  age;
    } entry_t;

endpackage

// ===== hdl/neighbor_table_with_aging_unit.sv =====
// Neighbor table with aging: hello lookup and insert, tick aging and expiry,
// periodic update scheduling; table kept in one synchronous entry memory.
// Depends on ntwa_pkg.
//
// The block takes one item at a time and answers each with exactly one result
// item. A hello sweeps the eight slots of its interface through the entry
// memory, one read a cycle from a registered read port, then writes the
// hit or the lowest free slot. A tick walks all TABLE_SIZE entries with a
// read-modify-write of the age, then sums the per-interface counts one
// interface a cycle. A finished result waits in an output register; the
// next item is taken while it waits, and the block stalls only when a
// second result is ready before the first is taken. Valid bits live in
// flip-flops cleared by reset, so no clearing pass is needed. Configuration
// is always ready and must be written only while the block is idle.
module neighbor_table_with_aging_unit
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, lowest bit up: iface_index[1:0], neighbor_id[33:2],
    // neighbor_ip[65:34], neighbor_mask[97:66], zero pad[103:98]
    input  logic [103:0] s_tdata,
    // tuser: mode[0]
    input  logic [0:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, lowest bit up: iface_neighbor_count[3:0], removed_count[9:4],
    // update_due[10], advert_count[16:11], zero pad[23:17]
    output logic [23:0]  m_tdata,
    // tuser: status[1:0]
    output logic [1:0]   m_tuser
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_H_SCAN = 3'd1;
    localparam logic [2:0] ST_H_DONE = 3'd2;
    localparam logic [2:0] ST_T_SCAN = 3'd3;
    localparam logic [2:0] ST_T_SUM  = 3'd4;
    localparam logic [2:0] ST_T_DONE = 3'd5;

    localparam int NPI = ntwa_pkg::NEIGHBORS_PER_IFACE;

    // state
    logic [2:0] state_reg, state_next;

    // item held during processing
    logic                           mode_reg, mode_next;
    logic                           bad_reg, bad_next;
    logic [ntwa_pkg::WORD_W-1:0]    id_reg, id_next;
    logic [ntwa_pkg::WORD_W-1:0]    ip_reg, ip_next;
    logic [ntwa_pkg::WORD_W-1:0]    mask_reg, mask_next;
    logic [ntwa_pkg::OWNER_W-1:0]   hello_owner_reg, hello_owner_next;

    // sweep control
    logic [ntwa_pkg::ADDR_W-1:0]    issue_addr_reg, issue_addr_next;
    logic [ntwa_pkg::SLOT_W-1:0]    issue_slot_reg, issue_slot_next;
    logic [ntwa_pkg::OWNER_W-1:0]   issue_owner_reg, issue_owner_next;
    logic [ntwa_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [ntwa_pkg::ADDR_W-1:0]    cmp_addr_reg, cmp_addr_next;
    logic [ntwa_pkg::OWNER_W-1:0]   cmp_owner_reg, cmp_owner_next;
    logic [ntwa_pkg::STEP_W-1:0]    step_last;

    // lookup results
    logic                           hit_found_reg, hit_found_next;
    logic [ntwa_pkg::ADDR_W-1:0]    hit_addr_reg, hit_addr_next;
    logic                           spare_found_reg, spare_found_next;
    logic [ntwa_pkg::ADDR_W-1:0]    spare_addr_reg, spare_addr_next;

    // tick accumulators
    logic [ntwa_pkg::SUM_W-1:0]     gone_reg, gone_next;
    logic [ntwa_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [ntwa_pkg::OWNER_W-1:0]   sum_idx_reg, sum_idx_next;

    // table control state
    logic [ntwa_pkg::TABLE_SIZE-1:0] valid_reg, valid_next;
    logic [ntwa_pkg::CNT_W-1:0]     count_reg [ntwa_pkg::NUM_IFACES];
    logic [ntwa_pkg::CNT_W-1:0]     count_next [ntwa_pkg::NUM_IFACES];
    logic [ntwa_pkg::CTR_W-1:0]     counter_reg, counter_next;
    logic [ntwa_pkg::INTV_W-1:0]    hello_int_reg, hello_int_next;
    logic [ntwa_pkg::INTV_W-1:0]    upd_int_reg, upd_int_next;

    // output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [1:0]                     out_status_reg, out_status_next;
    logic [3:0]                     out_count_reg, out_count_next;
    logic [5:0]                     out_removed_reg, out_removed_next;
    logic                           out_due_reg, out_due_next;
    logic [5:0]                     out_advert_reg, out_advert_next;

    // entry memory
    ntwa_pkg::entry_t               mem [ntwa_pkg::TABLE_SIZE];
    ntwa_pkg::entry_t               rd_data_reg;
    ntwa_pkg::entry_t               wr_data;
    logic                           rd_en, wr_en;
    logic [ntwa_pkg::ADDR_W-1:0]    rd_addr, wr_addr;

    // helpers
    logic                           out_free;
    logic [ntwa_pkg::OWNER_W-1:0]   cnt_idx;
    logic [ntwa_pkg::CNT_W-1:0]     cnt_sel;
    logic [ntwa_pkg::CTR_W:0]       push_sum;
    logic [ntwa_pkg::CTR_W-1:0]     push_val;
    logic [ntwa_pkg::CTR_W-1:0]     ctr_step;
    logic                           due_now;
    logic [ntwa_pkg::AGE_W-1:0]     limit;
    logic [ntwa_pkg::AGE_W-1:0]     age_new;
    logic [ntwa_pkg::CNT_W-1:0]     cnt_added;
    logic [ntwa_pkg::IFACE_W-1:0]   in_iface;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {7'd0, out_advert_reg, out_due_reg, out_removed_reg, out_count_reg};

    assign in_iface  = s_tdata[ntwa_pkg::IFACE_W-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;

    // expiry limit is three hello intervals
    assign limit = {2'b00, hello_int_reg} + {1'b0, hello_int_reg, 1'b0};

    // one shared read of the per-interface counts
    always_comb
    begin
        unique case (state_reg)
            ST_T_SCAN: cnt_idx = cmp_owner_reg;
            ST_T_SUM:  cnt_idx = sum_idx_reg;
            default:   cnt_idx = hello_owner_reg;
        endcase
    end
    assign cnt_sel   = count_reg[cnt_idx];
    assign cnt_added = cnt_sel + ntwa_pkg::CNT_W'(1);

    // saturating pushes of the update counter
    assign push_sum = {1'b0, counter_reg} + {{(ntwa_pkg::CTR_W + 1 - ntwa_pkg::INTV_W){1'b0}},
                                             upd_int_reg};
    assign push_val = push_sum[ntwa_pkg::CTR_W] ? ntwa_pkg::COUNTER_MAX
                                                : push_sum[ntwa_pkg::CTR_W-1:0];
    assign ctr_step = (counter_reg == ntwa_pkg::COUNTER_MAX) ? counter_reg
                                                             : counter_reg + 1'b1;
    assign due_now  = ctr_step > {{(ntwa_pkg::CTR_W - ntwa_pkg::INTV_W){1'b0}}, upd_int_reg};

    // saturating age step of the entry under compare
    assign age_new  = (rd_data_reg.age < ntwa_pkg::AGE_MAX) ? rd_data_reg.age + 1'b1
                                                            : rd_data_reg.age;

    assign step_last = (mode_reg == ntwa_pkg::MODE_TICK) ? ntwa_pkg::STEP_W'(ntwa_pkg::TABLE_SIZE)
                                                         : ntwa_pkg::STEP_W'(NPI);

    // sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        bad_next         = bad_reg;
        id_next          = id_reg;
        ip_next          = ip_reg;
        mask_next        = mask_reg;
        hello_owner_next = hello_owner_reg;
        issue_addr_next  = issue_addr_reg;
        issue_slot_next  = issue_slot_reg;
        issue_owner_next = issue_owner_reg;
        step_next        = step_reg;
        cmp_addr_next    = cmp_addr_reg;
        cmp_owner_next   = cmp_owner_reg;
        hit_found_next   = hit_found_reg;
        hit_addr_next    = hit_addr_reg;
        spare_found_next = spare_found_reg;
        spare_addr_next  = spare_addr_reg;
        gone_next        = gone_reg;
        sum_next         = sum_reg;
        sum_idx_next     = sum_idx_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        counter_next     = counter_reg;
        hello_int_next   = hello_int_reg;
        upd_int_next     = upd_int_reg;
        m_tvalid_next    = m_tvalid_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_removed_next = out_removed_reg;
        out_due_next     = out_due_reg;
        out_advert_next  = out_advert_reg;
        rd_en            = 1'b0;
        rd_addr          = issue_addr_reg;
        wr_en            = 1'b0;
        wr_addr          = cmp_addr_reg;
        wr_data          = rd_data_reg;

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ntwa_pkg::REG_HELLO_INTERVAL:  hello_int_next = cfg_data;
                ntwa_pkg::REG_UPDATE_INTERVAL: upd_int_next   = cfg_data;
                default:                       ;
            endcase
        end

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next        = s_tuser[0];
                    id_next          = s_tdata[33:2];
                    ip_next          = s_tdata[65:34];
                    mask_next        = s_tdata[97:66];
                    hello_owner_next = ntwa_pkg::OWNER_W'(in_iface);
                    bad_next         = (int'(in_iface) >= ntwa_pkg::NUM_IFACES);
                    step_next        = '0;
                    issue_slot_next  = '0;
                    hit_found_next   = 1'b0;
                    spare_found_next = 1'b0;
                    gone_next        = '0;
                    if (s_tuser[0] == ntwa_pkg::MODE_TICK)
                    begin
                        issue_addr_next  = '0;
                        issue_owner_next = '0;
                        state_next       = ST_T_SCAN;
                    end
                    else
                    begin
                        issue_addr_next  = ntwa_pkg::ADDR_W'(int'(in_iface) * NPI);
                        issue_owner_next = ntwa_pkg::OWNER_W'(in_iface);
                        if (int'(in_iface) >= ntwa_pkg::NUM_IFACES)
                        begin
                            state_next = ST_H_DONE;
                        end
                        else
                        begin
                            state_next = ST_H_SCAN;
                        end
                    end
                end
            end

            ST_H_SCAN, ST_T_SCAN:
            begin
                // issue the next read of the sweep
                if (step_reg < step_last)
                begin
                    rd_en           = 1'b1;
                    cmp_addr_next   = issue_addr_reg;
                    cmp_owner_next  = issue_owner_reg;
                    issue_addr_next = issue_addr_reg + 1'b1;
                    if (issue_slot_reg == ntwa_pkg::SLOT_W'(NPI - 1))
                    begin
                        issue_slot_next  = '0;
                        issue_owner_next = issue_owner_reg + 1'b1;
                    end
                    else
                    begin
                        issue_slot_next = issue_slot_reg + 1'b1;
                    end
                end
                step_next = step_reg + 1'b1;

                // evaluate the entry read in the previous cycle
                if (step_reg != '0)
                begin
                    if (state_reg == ST_H_SCAN)
                    begin
                        if (valid_reg[cmp_addr_reg])
                        begin
                            if (!hit_found_reg && rd_data_reg.id == id_reg)
                            begin
                                hit_found_next = 1'b1;
                                hit_addr_next  = cmp_addr_reg;
                            end
                        end
                        else if (!spare_found_reg)
                        begin
                            spare_found_next = 1'b1;
                            spare_addr_next  = cmp_addr_reg;
                        end
                    end
                    else if (valid_reg[cmp_addr_reg])
                    begin
                        if (age_new >= limit)
                        begin
                            valid_next[cmp_addr_reg] = 1'b0;
                            if (cnt_sel != '0)
                            begin
                                count_next[cmp_owner_reg] = cnt_sel - 1'b1;
                            end
                            counter_next = push_val;
                            gone_next    = gone_reg + 1'b1;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_data.age = age_new;
                        end
                    end
                end

                // sweep finished with the last compare
                if (step_reg == step_last)
                begin
                    if (state_reg == ST_H_SCAN)
                    begin
                        state_next = ST_H_DONE;
                    end
                    else
                    begin
                        sum_next     = '0;
                        sum_idx_next = '0;
                        state_next   = ST_T_SUM;
                    end
                end
            end

            ST_H_DONE:
            begin
                if (out_free)
                begin
                    wr_data.id   = id_reg;
                    wr_data.ip   = ip_reg;
                    wr_data.mask = mask_reg;
                    wr_data.age  = '0;
                    out_removed_next = '0;
                    out_due_next     = 1'b0;
                    out_advert_next  = '0;
                    out_count_next   = (int'(cnt_sel) > ntwa_pkg::IFACE_CNT_SAT)
                                       ? 4'(ntwa_pkg::IFACE_CNT_SAT) : 4'(cnt_sel);
                    if (bad_reg)
                    begin
                        out_status_next = ntwa_pkg::STATUS_FULL;
                        out_count_next  = '0;
                    end
                    else if (hit_found_reg)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = hit_addr_reg;
                        out_status_next = ntwa_pkg::STATUS_REFRESHED;
                    end
                    else if (spare_found_reg)
                    begin
                        wr_en                       = 1'b1;
                        wr_addr                     = spare_addr_reg;
                        valid_next[spare_addr_reg]  = 1'b1;
                        count_next[hello_owner_reg] = cnt_added;
                        counter_next                = push_val;
                        out_status_next             = ntwa_pkg::STATUS_ADDED;
                        out_count_next = (int'(cnt_added) > ntwa_pkg::IFACE_CNT_SAT)
                                         ? 4'(ntwa_pkg::IFACE_CNT_SAT) : 4'(cnt_added);
                    end
                    else
                    begin
                        out_status_next = ntwa_pkg::STATUS_FULL;
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_T_SUM:
            begin
                // sum of max(count, 1) over interfaces
                sum_next     = sum_reg + ((cnt_sel == '0) ? ntwa_pkg::SUM_W'(1)
                                                          : ntwa_pkg::SUM_W'(cnt_sel));
                sum_idx_next = sum_idx_reg + 1'b1;
                if (sum_idx_reg == ntwa_pkg::OWNER_W'(ntwa_pkg::NUM_IFACES - 1))
                begin
                    state_next = ST_T_DONE;
                end
            end

            ST_T_DONE:
            begin
                if (out_free)
                begin
                    out_status_next  = ntwa_pkg::STATUS_TICK_DONE;
                    out_count_next   = '0;
                    out_removed_next = (int'(gone_reg) > ntwa_pkg::WIDE_CNT_SAT)
                                       ? 6'(ntwa_pkg::WIDE_CNT_SAT) : 6'(gone_reg);
                    out_due_next     = due_now;
                    if (due_now)
                    begin
                        counter_next    = '0;
                        out_advert_next = (int'(sum_reg) > ntwa_pkg::WIDE_CNT_SAT)
                                          ? 6'(ntwa_pkg::WIDE_CNT_SAT) : 6'(sum_reg);
                    end
                    else
                    begin
                        counter_next    = ctr_step;
                        out_advert_next = '0;
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            for (int i = 0; i < ntwa_pkg::NUM_IFACES; i++)
            begin
                count_reg[i] <= '0;
            end
            counter_reg     <= '0;
            hello_int_reg   <= ntwa_pkg::HELLO_INTERVAL_RESET;
            upd_int_reg     <= ntwa_pkg::UPDATE_INTERVAL_RESET;
            m_tvalid_reg    <= 1'b0;
            mode_reg        <= ntwa_pkg::MODE_HELLO;
            bad_reg         <= 1'b0;
            step_reg        <= '0;
            hit_found_reg   <= 1'b0;
            spare_found_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            counter_reg     <= counter_next;
            hello_int_reg   <= hello_int_next;
            upd_int_reg     <= upd_int_next;
            m_tvalid_reg    <= m_tvalid_next;
            mode_reg        <= mode_next;
            bad_reg         <= bad_next;
            step_reg        <= step_next;
            hit_found_reg   <= hit_found_next;
            spare_found_reg <= spare_found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        ip_reg          <= ip_next;
        mask_reg        <= mask_next;
        hello_owner_reg <= hello_owner_next;
        issue_addr_reg  <= issue_addr_next;
        issue_slot_reg  <= issue_slot_next;
        issue_owner_reg <= issue_owner_next;
        cmp_addr_reg    <= cmp_addr_next;
        cmp_owner_reg   <= cmp_owner_next;
        hit_addr_reg    <= hit_addr_next;
        spare_addr_reg  <= spare_addr_next;
        gone_reg        <= gone_next;
        sum_reg         <= sum_next;
        sum_idx_reg     <= sum_idx_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
        out_removed_reg <= out_removed_next;
        out_due_reg     <= out_due_next;
        out_advert_reg  <= out_advert_next;
    end

    // per-interface count matches the valid slots of that interface
    for (genvar g = 0; g < ntwa_pkg::NUM_IFACES; g++)
    begin : g_count_check
        a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
            $countones(valid_reg[g*NPI +: NPI]) == int'(count_reg[g]))
            else $error("neighbor count out of step with valid slots");
    end

    // no table write while no item is being worked on
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("entry memory written while idle");

    // an update-due tick leaves the update counter cleared
    a_due_clears_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T_DONE && out_free && due_now) |=> (counter_reg == '0))
        else $error("update counter not cleared after update due");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for neighbor_table_with_aging_unit: hello and tick items
// are driven on the input stream and each result is checked against a table predictor.
// Depends on ntwa_pkg and the unit itself.
module tb_top;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 226;
    localparam int POOL_DEPTH   = 12;

    typedef struct packed {
        logic                        mode;
        logic [1:0]                  iface;
        logic [ntwa_pkg::WORD_W-1:0] id;
        logic [ntwa_pkg::WORD_W-1:0] ip;
        logic [ntwa_pkg::WORD_W-1:0] mask;
    } neighbor_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] count;
        logic [5:0] removed;
        logic       due;
        logic [5:0] adverts;
    } neighbor_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [7:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [1:0]   m_tuser;

    // predictor copy of registers and table
    logic [ntwa_pkg::INTV_W-1:0] hello_intv = ntwa_pkg::HELLO_INTERVAL_RESET;
    logic [ntwa_pkg::INTV_W-1:0] update_intv = ntwa_pkg::UPDATE_INTERVAL_RESET;
    logic                        slot_used [ntwa_pkg::TABLE_SIZE];
    logic [ntwa_pkg::WORD_W-1:0] slot_id [ntwa_pkg::TABLE_SIZE];
    logic [ntwa_pkg::WORD_W-1:0] slot_ip [ntwa_pkg::TABLE_SIZE];
    logic [ntwa_pkg::WORD_W-1:0] slot_mask [ntwa_pkg::TABLE_SIZE];
    int unsigned                 slot_age [ntwa_pkg::TABLE_SIZE];
    int unsigned                 iface_nbrs [ntwa_pkg::NUM_IFACES];
    int unsigned                 lsu_counter = 0;

    neighbor_item_t              pending_items[$];
    neighbor_result_t            expected_results[$];
    neighbor_item_t              cur_item;
    logic [ntwa_pkg::WORD_W-1:0] id_pool [ntwa_pkg::NUM_IFACES][POOL_DEPTH];
    int                          send_idle_pct = 20;
    int                          recv_idle_pct = 20;
    int                          mismatches = 0;
    int                          stall_cycles = 0;

    neighbor_table_with_aging_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // saturating push of the update counter
    function automatic void bump_lsu_counter(input int unsigned amount);
        lsu_counter = (lsu_counter + amount > ntwa_pkg::COUNTER_MAX) ? ntwa_pkg::COUNTER_MAX
                                                                     : lsu_counter + amount;
    endfunction

    // next table state and result for one item
    function automatic neighbor_result_t predict_neighbor_result(input neighbor_item_t it);
        neighbor_result_t res;
        int unsigned      base;
        int unsigned      hit;
        int unsigned      spare;
        int unsigned      limit;
        int unsigned      gone;
        int unsigned      total;
        int unsigned      owner;
        int unsigned      k;
        res = '0;
        if (it.mode == ntwa_pkg::MODE_HELLO)
        begin
            if (it.iface >= ntwa_pkg::NUM_IFACES)
            begin
                res.status = ntwa_pkg::STATUS_FULL;
            end
            else
            begin
                base  = it.iface * ntwa_pkg::NEIGHBORS_PER_IFACE;
                hit   = ntwa_pkg::TABLE_SIZE;
                spare = ntwa_pkg::TABLE_SIZE;
                // lookup of the id and of the lowest free slot
                for (k = base; k < base + ntwa_pkg::NEIGHBORS_PER_IFACE; k++)
                begin
                    if (slot_used[k])
                    begin
                        if (hit == ntwa_pkg::TABLE_SIZE && slot_id[k] == it.id)
                            hit = k;
                    end
                    else if (spare == ntwa_pkg::TABLE_SIZE)
                    begin
                        spare = k;
                    end
                end
                if (hit != ntwa_pkg::TABLE_SIZE)
                begin
                    res.status = ntwa_pkg::STATUS_REFRESHED;
                end
                else if (spare != ntwa_pkg::TABLE_SIZE)
                begin
                    hit = spare;
                    slot_used[hit] = 1'b1;
                    slot_id[hit] = it.id;
                    iface_nbrs[it.iface]++;
                    bump_lsu_counter(update_intv);
                    res.status = ntwa_pkg::STATUS_ADDED;
                end
                else
                begin
                    res.status = ntwa_pkg::STATUS_FULL;
                end
                if (hit != ntwa_pkg::TABLE_SIZE)
                begin
                    slot_ip[hit]   = it.ip;
                    slot_mask[hit] = it.mask;
                    slot_age[hit]  = 0;
                end
                res.count = 4'((iface_nbrs[it.iface] > ntwa_pkg::IFACE_CNT_SAT)
                               ? ntwa_pkg::IFACE_CNT_SAT : iface_nbrs[it.iface]);
            end
        end
        else
        begin
            limit = 3 * hello_intv;
            gone  = 0;
            total = 0;
            // aging and expiry sweep
            for (k = 0; k < ntwa_pkg::TABLE_SIZE; k++)
            begin
                if (!slot_used[k])
                    continue;
                if (slot_age[k] < ntwa_pkg::AGE_MAX)
                    slot_age[k]++;
                if (slot_age[k] >= limit)
                begin
                    owner = k / ntwa_pkg::NEIGHBORS_PER_IFACE;
                    slot_used[k] = 1'b0;
                    if (iface_nbrs[owner] > 0)
                        iface_nbrs[owner]--;
                    bump_lsu_counter(update_intv);
                    gone++;
                end
            end
            // periodic update scheduling
            bump_lsu_counter(1);
            if (lsu_counter > update_intv)
            begin
                lsu_counter = 0;
                res.due = 1'b1;
                for (k = 0; k < ntwa_pkg::NUM_IFACES; k++)
                    total += (iface_nbrs[k] != 0) ? iface_nbrs[k] : 1;
                res.adverts = 6'((total > ntwa_pkg::WIDE_CNT_SAT) ? ntwa_pkg::WIDE_CNT_SAT
                                                                  : total);
            end
            res.removed = 6'((gone > ntwa_pkg::WIDE_CNT_SAT) ? ntwa_pkg::WIDE_CNT_SAT : gone);
            res.status  = ntwa_pkg::STATUS_TICK_DONE;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // compare one result item with the oldest expectation
    task automatic check_result(input neighbor_result_t got);
        neighbor_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected, status %0d", got.status));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.count !== want.count)
            report_mismatch($sformatf("iface_neighbor_count %0d, want %0d",
                                      got.count, want.count));
        if (got.removed !== want.removed)
            report_mismatch($sformatf("removed_count %0d, want %0d",
                                      got.removed, want.removed));
        if (got.due !== want.due)
            report_mismatch($sformatf("update_due %0d, want %0d", got.due, want.due));
        if (got.adverts !== want.adverts)
            report_mismatch($sformatf("advert_count %0d, want %0d",
                                      got.adverts, want.adverts));
    endtask

    // input driver, fed from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_neighbor_result(cur_item));
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, cur_item.mask, cur_item.ip, cur_item.id, cur_item.iface};
                    s_tuser  <= cur_item.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result({m_tuser, m_tdata[3:0], m_tdata[9:4], m_tdata[10],
                              m_tdata[16:11]});
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void add_hello(input logic [1:0] iface, input logic [31:0] id,
                                      input logic [31:0] ip, input logic [31:0] mask);
        pending_items.push_back(neighbor_item_t'{ntwa_pkg::MODE_HELLO, iface, id, ip, mask});
    endfunction

    function automatic void add_tick();
        pending_items.push_back(neighbor_item_t'{ntwa_pkg::MODE_TICK, 2'($urandom),
                                                 $urandom, $urandom, $urandom});
    endfunction

    // mostly known neighbors so that refreshes, full tables and expiry all occur
    function automatic void add_random_item(input int tick_pct);
        logic [1:0]  iface;
        logic [31:0] id;
        iface = 2'($urandom_range(ntwa_pkg::NUM_IFACES - 1));
        if ($urandom_range(99) < tick_pct)
        begin
            add_tick();
        end
        else
        begin
            if ($urandom_range(99) < 85)
                id = id_pool[iface][$urandom_range(POOL_DEPTH - 1)];
            else
                id = $urandom;
            add_hello(iface, id, $urandom, $urandom);
        end
    endfunction

    // sender holds off until every expected result has come, then the block drains
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write, called at a rising edge
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == ntwa_pkg::REG_HELLO_INTERVAL)
            hello_intv = val;
        else if (idx == ntwa_pkg::REG_UPDATE_INTERVAL)
            update_intv = val;
    endtask

    // stimulus and end of run
    initial
    begin
        int tick_pct;
        foreach (slot_used[k])
        begin
            slot_used[k] = 1'b0;
            slot_age[k]  = 0;
        end
        foreach (iface_nbrs[k])
            iface_nbrs[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, refresh, add, full interface, ticks
        add_hello(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_hello(2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_hello(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        for (int k = 0; k < ntwa_pkg::NEIGHBORS_PER_IFACE; k++)
            add_hello(2'd1, 32'h5555_0000 | k, 32'h0A00_0000 | k, 32'hFFFF_FF00);
        add_hello(2'd1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        add_hello(2'd1, 32'h5555_0003, 32'h0B00_0003, 32'hFFFF_0000);
        add_tick();
        add_hello(2'd2, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFC);
        add_tick();
        wait_idle();

        // zero hello interval expires everything, zero update interval makes every tick due
        write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'd0);
        write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'd0);
        write_reg(8'd2, 8'hFF);
        write_reg(8'hFF, 8'h01);
        cfg_valid <= 1'b0;
        @(negedge clk);
        add_tick();
        add_tick();
        add_hello(2'd2, 32'h0000_0000, 32'hC0A8_0001, 32'hFFFF_FF00);
        add_tick();
        wait_idle();

        // random phases over a spread of register settings
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'd1);
                    write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'd1);
                end
                1:
                begin
                    write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'd255);
                    write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'd255);
                end
                2:
                begin
                    write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'd2);
                    write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'd20);
                end
                3:
                begin
                    write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'd0);
                    write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'd7);
                end
                4:
                begin
                    write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'd4);
                    write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'd0);
                end
                5:
                begin
                    write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'd3);
                    write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'd100);
                end
                default:
                begin
                    write_reg(ntwa_pkg::REG_HELLO_INTERVAL, 8'($urandom_range(12, 1)));
                    write_reg(ntwa_pkg::REG_UPDATE_INTERVAL, 8'($urandom_range(255)));
                end
            endcase
            cfg_valid <= 1'b0;
            @(negedge clk);
            // one phase runs back to back on both sides
            send_idle_pct = (phase == 2) ? 0 : 20;
            recv_idle_pct = (phase == 2) ? 0 : 20;
            foreach (id_pool[i, j])
                id_pool[i][j] = $urandom;
            // hold ticks off at the start of the saturation phase so the counter fills up
            tick_pct = (phase == 1) ? 0 : $urandom_range(40, 15);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 60)
                    tick_pct = 25;
                add_random_item(tick_pct);
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
